/* rtl/core/sip_hnc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sip_hnc_pkg
// Types, constants and the transition functions shared by the SIP header
// name classifier.
// ----------------------------------------------------------------------------
package sip_hnc_pkg;

    // scan length limit and the saturation point of the byte position
    localparam int MAX_SCAN_LENGTH = 1024;
    localparam int POS_CAP_INT     = ((MAX_SCAN_LENGTH - 1) < 1023) ?
                                     (MAX_SCAN_LENGTH - 1) : 1023;
    localparam logic [9:0] POS_CAP = 10'(POS_CAP_INT);

    // special characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [3:0] {
        KIND_VIA      = 4'd0,
        KIND_FROM     = 4'd1,
        KIND_TO       = 4'd2,
        KIND_CSEQ     = 4'd3,
        KIND_CALLID   = 4'd4,
        KIND_CONTACT  = 4'd5,
        KIND_MAXFWD   = 4'd6,
        KIND_ROUTE    = 4'd7,
        KIND_RECROUTE = 4'd8,
        KIND_OTHER    = 4'd9,
        KIND_ERROR    = 4'd10
    } header_kind_t;

    typedef enum logic [5:0] {
        S_INIT, S_V1, S_V2, S_F1, S_F2, S_F3, S_T1,
        S_C, S_CS2, S_CS3, S_CI2, S_CI3, S_CI4, S_CI5, S_CI6,
        S_CO2, S_CO3, S_CO4, S_CO5, S_CO6,
        S_M, S_MF2, S_MF3, S_MF4, S_MF5, S_MF6, S_MF7, S_MF8, S_MF9, S_MF10,
        S_MF11,
        S_R1, S_R2, S_R3, S_R4,
        S_RR1, S_RR2, S_RR3, S_RR4, S_RR5, S_RR6, S_RR7, S_RR8, S_RR9, S_RR10,
        S_I,
        S_FVIA, S_FFROM, S_FTO, S_FCSEQ, S_FCALLID, S_FCONTACT, S_FMAXF,
        S_FROUTE, S_FRR,
        S_UNK
    } scan_state_t;

    // one scan step result handed from the scanner to the output stage
    typedef struct packed {
        logic         emit;
        header_kind_t kind;
        logic [9:0]   start;
        logic [9:0]   length;
        logic [9:0]   end_pos;
    } scan_result_t;

    // automaton move on a lower-case byte; unlisted pairs go to S_UNK
    function automatic scan_state_t move_state(scan_state_t st, logic [7:0] ch);
        scan_state_t nx;
        nx = S_UNK;
        case (st)
            S_INIT: begin
                if (ch == "v")      nx = S_V1;
                else if (ch == "i") nx = S_I;
                else if (ch == "f") nx = S_F1;
                else if (ch == "r") nx = S_R1;
                else if (ch == "m") nx = S_M;
                else if (ch == "t") nx = S_T1;
                else if (ch == "c") nx = S_C;
            end
            S_V1: begin
                if (ch == "i")           nx = S_V2;
                else if (ch == CH_SPACE) nx = S_FVIA;
            end
            S_V2:  if (ch == "a") nx = S_FVIA;
            S_F1: begin
                if (ch == "r")           nx = S_F2;
                else if (ch == CH_SPACE) nx = S_FFROM;
            end
            S_F2:  if (ch == "o") nx = S_F3;
            S_F3:  if (ch == "m") nx = S_FFROM;
            S_T1: begin
                if (ch == "o")           nx = S_FTO;
                else if (ch == CH_SPACE) nx = S_FTO;
            end
            S_C: begin
                if (ch == "s")      nx = S_CS2;
                else if (ch == "a") nx = S_CI2;
                else if (ch == "o") nx = S_CO2;
            end
            S_CS2: if (ch == "e") nx = S_CS3;
            S_CS3: if (ch == "q") nx = S_FCSEQ;
            S_CI2: if (ch == "l") nx = S_CI3;
            S_CI3: if (ch == "l") nx = S_CI4;
            S_CI4: if (ch == CH_DASH) nx = S_CI5;
            S_CI5: if (ch == "i") nx = S_CI6;
            S_CI6: if (ch == "d") nx = S_FCALLID;
            S_CO2: if (ch == "n") nx = S_CO3;
            S_CO3: if (ch == "t") nx = S_CO4;
            S_CO4: if (ch == "a") nx = S_CO5;
            S_CO5: if (ch == "c") nx = S_CO6;
            S_CO6: if (ch == "t") nx = S_FCONTACT;
            S_M: begin
                if (ch == "a")           nx = S_MF2;
                else if (ch == CH_SPACE) nx = S_FCONTACT;
            end
            S_MF2:  if (ch == "x") nx = S_MF3;
            S_MF3:  if (ch == CH_DASH) nx = S_MF4;
            S_MF4:  if (ch == "f") nx = S_MF5;
            S_MF5:  if (ch == "o") nx = S_MF6;
            S_MF6:  if (ch == "r") nx = S_MF7;
            S_MF7:  if (ch == "w") nx = S_MF8;
            S_MF8:  if (ch == "a") nx = S_MF9;
            S_MF9:  if (ch == "r") nx = S_MF10;
            S_MF10: if (ch == "d") nx = S_MF11;
            S_MF11: if (ch == "s") nx = S_FMAXF;
            S_R1: begin
                if (ch == "o")      nx = S_R2;
                else if (ch == "e") nx = S_RR1;
            end
            S_R2:   if (ch == "u") nx = S_R3;
            S_R3:   if (ch == "t") nx = S_R4;
            S_R4:   if (ch == "e") nx = S_FROUTE;
            S_RR1:  if (ch == "c") nx = S_RR2;
            S_RR2:  if (ch == "o") nx = S_RR3;
            S_RR3:  if (ch == "r") nx = S_RR4;
            S_RR4:  if (ch == "d") nx = S_RR5;
            S_RR5:  if (ch == CH_DASH) nx = S_RR6;
            S_RR6:  if (ch == "r") nx = S_RR7;
            S_RR7:  if (ch == "o") nx = S_RR8;
            S_RR8:  if (ch == "u") nx = S_RR9;
            S_RR9:  if (ch == "t") nx = S_RR10;
            S_RR10: if (ch == "e") nx = S_FRR;
            S_I:    if (ch == CH_SPACE) nx = S_FCALLID;
            default: nx = S_UNK;
        endcase
        return nx;
    endfunction

    // header kind reported when a colon arrives in a given state
    function automatic header_kind_t colon_kind(scan_state_t st);
        header_kind_t k;
        case (st)
            S_FVIA, S_V1:      k = KIND_VIA;
            S_FFROM, S_F1:     k = KIND_FROM;
            S_FTO, S_T1:       k = KIND_TO;
            S_FCSEQ:           k = KIND_CSEQ;
            S_FCALLID, S_I:    k = KIND_CALLID;
            S_FCONTACT, S_M:   k = KIND_CONTACT;
            S_FMAXF:           k = KIND_MAXFWD;
            S_FROUTE:          k = KIND_ROUTE;
            S_FRR:             k = KIND_RECROUTE;
            default:           k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage : sip_hnc_pkg
`default_nettype wire

/* rtl/core/sip_hnc_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sip_hnc_scan
// Header name automaton with position bookkeeping; computes the result of
// the current byte and advances the scan state when stepped.
// ----------------------------------------------------------------------------
module sip_hnc_scan
    import sip_hnc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step_en,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_data,
    output scan_result_t      result
);

    scan_state_t state_reg, state_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  begin_reg, begin_next;
    logic        seen_reg, seen_next;

    logic [7:0]  ch;
    logic        is_colon;
    logic        is_eol;
    logic        is_final;
    logic [9:0]  colon_start;

    // fold upper case to lower case
    always_comb begin
        if (data_byte inside {[8'h41:8'h5A]}) ch = data_byte + 8'd32;
        else                                  ch = data_byte;
    end

    assign is_colon    = (data_byte == CH_COLON);
    assign is_eol      = (data_byte == CH_LF) || (data_byte == CH_CR);
    assign is_final    = (state_reg inside {[S_FVIA:S_FRR]});
    assign colon_start = seen_reg ? begin_reg : pos_reg;

    // result of this byte and next scan state
    always_comb begin
        result.emit    = 1'b0;
        result.kind    = KIND_ERROR;
        result.start   = '0;
        result.length  = '0;
        result.end_pos = pos_reg;
        state_next     = state_reg;
        begin_next     = begin_reg;
        seen_next      = seen_reg;

        if (is_colon) begin
            result.emit   = 1'b1;
            result.kind   = colon_kind(state_reg);
            result.start  = colon_start;
            result.length = pos_reg - colon_start;
        end else if (is_eol) begin
            result.emit = 1'b1;
        end else begin
            if (state_reg == S_INIT) begin
                if (ch != CH_SPACE) begin
                    begin_next = pos_reg;
                    seen_next  = 1'b1;
                    state_next = move_state(S_INIT, ch);
                end
            end else if (!(ch == CH_SPACE && is_final)) begin
                state_next = move_state(state_reg, ch);
            end
            result.emit = end_of_data;
        end

        // restart after every result, else advance with saturation
        if (result.emit) begin
            state_next = S_INIT;
            pos_next   = '0;
            begin_next = '0;
            seen_next  = 1'b0;
        end else if (pos_reg < POS_CAP) begin
            pos_next = pos_reg + 10'd1;
        end else begin
            pos_next = pos_reg;
        end
    end

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            pos_reg   <= '0;
            begin_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            seen_reg  <= seen_next;
        end
    end

endmodule : sip_hnc_scan
`default_nettype wire

/* rtl/core/sip_header_name_classifier_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sip_header_name_classifier_unit
// Classifies a SIP header name arriving one byte per request and reports
// kind, start, length and end position on colon, line end or end of data.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                                | tuser / tlast
//  s_      | in        | data_byte [7:0]                      | tlast = end_of_data
//  m_      | out       | kind, start, length, end_pos (40 b)  | -
//
//  One byte per cycle sustained while the result side is ready; a taken byte
//  passes the input register, then the automaton step, into the result register.
//  The automaton state updates on each stepped byte.
//  Synchronous active-low reset returns the scan to its start.
//  A stalled result holds both stages; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module sip_header_name_classifier_unit
    import sip_hnc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_data

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [3:0] header_kind, [13:4] name_start,
                                        // [23:14] name_length,
                                        // [33:24] end_position, [39:34] zero
);

    logic         in_vld_reg, in_vld_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_vld_reg, out_vld_next;
    scan_result_t out_reg;
    scan_result_t step_result;
    logic         advance;
    logic         step_en;

    // pipeline handshake
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign step_en  = in_vld_reg && advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) in_vld_next = 1'b1;
        else if (advance)         in_vld_next = 1'b0;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) out_vld_next = step_en && step_result.emit;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // automaton step
    sip_hnc_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .end_of_data (in_last_reg),
        .result      (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.end_pos, out_reg.length, out_reg.start,
                       out_reg.kind};

endmodule : sip_header_name_classifier_unit
`default_nettype wire

/* tb/sip_hnc_result_monitor.sv */
// ----------------------------------------------------------------------------
// sip_hnc_result_monitor
// Watches both streams of the header name classifier, predicts the report
// that each accepted byte request causes and compares every report taken
// from the result stream against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sip_hnc_result_monitor
    import sip_hnc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_data

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // [3:0] header_kind, [13:4] name_start,
                                        // [23:14] name_length,
                                        // [33:24] end_position

    output int               fail_count,
    output int               reports_awaited
);

    // progress of the name match within one scan
    typedef enum logic [1:0] {
        NAME_IDLE,
        NAME_PARTIAL,
        NAME_WHOLE,
        NAME_BROKEN
    } name_phase_t;

    typedef struct packed {
        header_kind_t kind;
        logic [9:0]   start;
        logic [9:0]   length;
        logic [9:0]   end_pos;
    } header_report_t;

    header_report_t awaited_reports [$];

    name_phase_t    phase;
    header_kind_t   whole_kind;
    logic [7:0]     name_chars [16];
    int             name_len;
    logic [9:0]     cursor;
    logic [9:0]     name_first;

    // lower-case spelling of each long header name
    function automatic string spelled_name(header_kind_t k);
        case (k)
            KIND_VIA:      return "via";
            KIND_FROM:     return "from";
            KIND_TO:       return "to";
            KIND_CSEQ:     return "cseq";
            KIND_CALLID:   return "call-id";
            KIND_CONTACT:  return "contact";
            KIND_MAXFWD:   return "max-forwards";
            KIND_ROUTE:    return "route";
            KIND_RECROUTE: return "record-route";
            default:       return "";
        endcase
    endfunction

    // single letter compact forms
    function automatic logic compact_kind(logic [7:0] c, output header_kind_t k);
        k = KIND_OTHER;
        case (c)
            "v": k = KIND_VIA;
            "f": k = KIND_FROM;
            "t": k = KIND_TO;
            "i": k = KIND_CALLID;
            "m": k = KIND_CONTACT;
            default: k = KIND_OTHER;
        endcase
        return k != KIND_OTHER;
    endfunction

    function automatic void restart_scan();
        phase      = NAME_IDLE;
        whole_kind = KIND_OTHER;
        name_len   = 0;
        cursor     = '0;
        name_first = '0;
    endfunction

    // extend the partial name by one lower-case byte
    function automatic void take_name_byte(logic [7:0] c);
        header_kind_t k;
        string        nm;
        logic         alive;
        logic         same;
        int           i;
        int           j;
        // a compact letter followed by a space is a whole name
        if (name_len == 1 && c == CH_SPACE && compact_kind(name_chars[0], k)) begin
            phase      = NAME_WHOLE;
            whole_kind = k;
            return;
        end
        if (name_len >= 16) begin
            phase = NAME_BROKEN;
            return;
        end
        name_chars[name_len] = c;
        name_len++;
        alive = (name_len == 1) && compact_kind(c, k);
        for (i = 0; i <= 8; i++) begin
            nm   = spelled_name(header_kind_t'(i));
            same = (name_len <= nm.len());
            for (j = 0; same && j < name_len; j++)
                if (nm[j] != name_chars[j])
                    same = 1'b0;
            if (same && name_len == nm.len()) begin
                phase      = NAME_WHOLE;
                whole_kind = header_kind_t'(i);
                return;
            end
            if (same)
                alive = 1'b1;
        end
        phase = alive ? NAME_PARTIAL : NAME_BROKEN;
    endfunction

    // one byte request through the classifier; queue the report it causes
    function automatic void classify_byte(logic [7:0] b, logic last);
        header_report_t r;
        header_kind_t   k;
        logic [7:0]     c;
        logic           emit;
        r         = '0;
        r.end_pos = cursor;
        emit      = 1'b0;
        c         = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (b == CH_COLON) begin
            if (phase == NAME_WHOLE)
                r.kind = whole_kind;
            else if (phase == NAME_PARTIAL && name_len == 1 &&
                     compact_kind(name_chars[0], k))
                r.kind = k;
            else
                r.kind = KIND_OTHER;
            r.start  = (phase != NAME_IDLE) ? name_first : cursor;
            r.length = cursor - r.start;
            emit     = 1'b1;
        end else if (b == CH_CR || b == CH_LF) begin
            r.kind = KIND_ERROR;
            emit   = 1'b1;
        end else begin
            if (phase == NAME_IDLE) begin
                // leading spaces are skipped
                if (c != CH_SPACE) begin
                    name_first = cursor;
                    name_len   = 0;
                    phase      = NAME_PARTIAL;
                    take_name_byte(c);
                end
            end else if (phase == NAME_WHOLE) begin
                if (c != CH_SPACE)
                    phase = NAME_BROKEN;
            end else if (phase == NAME_PARTIAL) begin
                take_name_byte(c);
            end
            if (last) begin
                r.kind = KIND_ERROR;
                emit   = 1'b1;
            end
        end
        if (emit) begin
            awaited_reports.push_back(r);
            restart_scan();
        end else if (cursor < POS_CAP) begin
            cursor = cursor + 10'd1;
        end
    endfunction

    // compare reports first, then predict from the byte request of this edge
    always @(posedge aclk) begin : watch
        header_report_t want;
        if (!aresetn) begin
            restart_scan();
            awaited_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $error("unexpected report: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_tdata[3:0] !== want.kind) begin
                        $error("header_kind: expected %0d, actual %0d",
                               want.kind, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[13:4] !== want.start) begin
                        $error("name_start: expected %0d, actual %0d",
                               want.start, m_tdata[13:4]);
                        fail_count++;
                    end
                    if (m_tdata[23:14] !== want.length) begin
                        $error("name_length: expected %0d, actual %0d",
                               want.length, m_tdata[23:14]);
                        fail_count++;
                    end
                    if (m_tdata[33:24] !== want.end_pos) begin
                        $error("end_position: expected %0d, actual %0d",
                               want.end_pos, m_tdata[33:24]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                classify_byte(s_tdata, s_tlast);
        end
        reports_awaited = awaited_reports.size();
    end

endmodule

/* tb/tb_sip_header_name_classifier_unit.sv */
// ----------------------------------------------------------------------------
// tb_sip_header_name_classifier_unit
// Drives header lines into the classifier: a few hand-picked cases, then
// random header names, broken names, noise and line ends, with random
// idling on both streams. The result monitor checks every report and
// counts failures.
// ----------------------------------------------------------------------------
module tb_sip_header_name_classifier_unit;
    import sip_hnc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // end_of_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [3:0] header_kind, [13:4] name_start,
                            // [23:14] name_length, [33:24] end_position

    int fail_count;
    int reports_awaited;
    int bytes_sent;
    int ready_run;
    bit calm;

    sip_header_name_classifier_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sip_hnc_result_monitor name_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .reports_awaited (reports_awaited)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // result side stalls in bursts, steady once calm
    always @(negedge aclk) begin
        if (calm)
            m_tready <= 1'b1;
        else if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if ($urandom_range(0, 1)) begin
            m_tready  <= 1'b0;
            ready_run <= $urandom_range(0, 18);
        end else begin
            m_tready  <= 1'b1;
            ready_run <= $urandom_range(0, 60);
        end
    end

    // header names, long forms first, then compact letters
    function automatic string header_text(int idx);
        case (idx)
            0:       return "via";
            1:       return "from";
            2:       return "to";
            3:       return "cseq";
            4:       return "call-id";
            5:       return "contact";
            6:       return "max-forwards";
            7:       return "route";
            8:       return "record-route";
            9:       return "v";
            10:      return "f";
            11:      return "t";
            12:      return "i";
            default: return "m";
        endcase
    endfunction

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1))
            return c - 8'd32;
        return c;
    endfunction

    // one byte request, called and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string t, input logic last);
        int i;
        for (i = 0; i < t.len(); i++)
            send_byte(t[i], last && (i == t.len() - 1));
    endtask

    // hold off requests until every report has come back
    task automatic wait_for_reports();
        s_tvalid = 1'b0;
        while (reports_awaited != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin : stimulus
        string txt;
        int    pick;
        int    pad;
        int    cut;
        int    bad;
        int    n;
        int    i;
        int    base;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // hand-picked cases: bare colon, line ends, compact and partial names
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("T:", 1'b0);
        send_text(" i :", 1'b0);
        send_text("Ca:", 1'b0);
        send_text("to  :", 1'b0);
        send_byte("q", 1'b1);
        send_byte(CH_COLON, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_LF, 1'b0);
        wait_for_reports();

        // random lines, mostly well-formed names
        base = bytes_sent;
        while (bytes_sent - base < 730) begin
            if (bytes_sent - base > 630)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                txt = header_text($urandom_range(0, 13));
                pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                repeat (pad) send_byte(CH_SPACE, 1'b0);
                for (i = 0; i < txt.len(); i++)
                    send_byte(mixed_case(txt[i]), 1'b0);
                pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                repeat (pad) send_byte(CH_SPACE, 1'b0);
                send_byte(CH_COLON, $urandom_range(0, 9) == 0);
                // header value up to the line end
                if ($urandom_range(0, 1)) begin
                    n = $urandom_range(0, 12);
                    repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                    send_byte(CH_CR, 1'b0);
                    send_byte(CH_LF, 1'b0);
                end
            end else if (pick < 70) begin
                // truncated or misspelled name
                txt = header_text($urandom_range(0, 8));
                cut = $urandom_range(1, txt.len());
                bad = $urandom_range(0, cut);
                for (i = 0; i < cut; i++)
                    send_byte((i == bad) ? 8'($urandom_range(8'h21, 8'h7E))
                                         : mixed_case(txt[i]), 1'b0);
                send_byte(CH_COLON, 1'b0);
            end else if (pick < 80) begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom_range(0, 255)),
                                     $urandom_range(0, 7) == 0);
            end else if (pick < 90) begin
                // data ends inside the name
                txt = header_text($urandom_range(0, 13));
                cut = $urandom_range(1, txt.len());
                for (i = 0; i < cut; i++)
                    send_byte(mixed_case(txt[i]), i == cut - 1);
            end else begin
                n = $urandom_range(0, 2);
                repeat (n) send_byte(CH_SPACE, 1'b0);
                send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, $urandom_range(0, 3) == 0);
            end
            if (!calm && $urandom_range(0, 39) == 0)
                wait_for_reports();
        end

        calm = 1'b1;
        wait_for_reports();
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/sip_hnc_pkg.sv
rtl/core/sip_hnc_scan.sv
rtl/core/sip_header_name_classifier_unit.sv
tb/sip_hnc_result_monitor.sv
tb/tb_sip_header_name_classifier_unit.sv
